/* hdl/hsal_pkg.sv */
// ----------------------------------------------------------------------------
// hsal_pkg
// shared types, constants and the control store of the hourly logger
// ----------------------------------------------------------------------------
package hsal_pkg;

  localparam int          HISTORY_DEPTH_DEF = 60;
  // working width for slot and offset arithmetic, covers depth up to 255 plus offset
  localparam int          CMP_W             = 9;
  localparam int          STEP_W            = 4;
  localparam logic [7:0]  EMPTY_MARK        = 8'hFF;
  localparam logic [6:0]  LIMIT_RESET       = 7'd99;

  typedef struct packed {
    logic [5:0]        minute_now;
    logic signed [7:0] temperature_sample;
    logic signed [7:0] humidity_sample;
    logic              sensor_ok;
    logic [5:0]        history_offset;
  } in_t;

  typedef struct packed {
    logic [7:0] temperature_shown;
    logic [7:0] humidity_shown;
    logic       entry_empty;
    logic       data_changed;
    logic       sample_taken;
    logic [5:0] current_slot;
  } out_t;

  // datapath operations
  typedef enum logic [3:0] {
    U_ACCEPT,
    U_MOD,
    U_NOP,
    U_DIV_INIT,
    U_DIV_STEP,
    U_CLOSE_HOUR,
    U_SAMPLE,
    U_READ,
    U_EMIT
  } uop_e;

  // jump conditions
  typedef enum logic [2:0] {
    C_NEVER,
    C_NO_REQ,
    C_OFF_GE,
    C_NOT_WRAP,
    C_CNT_ZERO,
    C_DIV_BUSY,
    C_OUT_BUSY
  } cond_e;

  typedef logic [STEP_W-1:0] step_t;

  typedef struct packed {
    uop_e  op;
    cond_e cond;
    step_t jump_to;
    step_t next_to;
  } ucode_t;

  localparam step_t S_ACCEPT   = 4'd0;
  localparam step_t S_MOD      = 4'd1;
  localparam step_t S_BRANCH   = 4'd2;
  localparam step_t S_DIV_INIT = 4'd3;
  localparam step_t S_DIV_STEP = 4'd4;
  localparam step_t S_CLOSE    = 4'd5;
  localparam step_t S_SAMPLE   = 4'd6;
  localparam step_t S_READ     = 4'd7;
  localparam step_t S_EMIT     = 4'd8;

  // control store: one word per step
  function automatic ucode_t ucode_rom(step_t step);
    ucode_t w;
    unique case (step)
      S_ACCEPT:   w = '{op: U_ACCEPT,     cond: C_NO_REQ,   jump_to: S_ACCEPT,
                        next_to: S_MOD};
      S_MOD:      w = '{op: U_MOD,        cond: C_OFF_GE,   jump_to: S_MOD,
                        next_to: S_BRANCH};
      S_BRANCH:   w = '{op: U_NOP,        cond: C_NOT_WRAP, jump_to: S_SAMPLE,
                        next_to: S_DIV_INIT};
      S_DIV_INIT: w = '{op: U_DIV_INIT,   cond: C_CNT_ZERO, jump_to: S_CLOSE,
                        next_to: S_DIV_STEP};
      S_DIV_STEP: w = '{op: U_DIV_STEP,   cond: C_DIV_BUSY, jump_to: S_DIV_STEP,
                        next_to: S_CLOSE};
      S_CLOSE:    w = '{op: U_CLOSE_HOUR, cond: C_NEVER,    jump_to: S_ACCEPT,
                        next_to: S_SAMPLE};
      S_SAMPLE:   w = '{op: U_SAMPLE,     cond: C_NEVER,    jump_to: S_ACCEPT,
                        next_to: S_READ};
      S_READ:     w = '{op: U_READ,       cond: C_NEVER,    jump_to: S_ACCEPT,
                        next_to: S_EMIT};
      S_EMIT:     w = '{op: U_EMIT,       cond: C_OUT_BUSY, jump_to: S_EMIT,
                        next_to: S_ACCEPT};
      default:    w = '{op: U_NOP,        cond: C_NEVER,    jump_to: S_ACCEPT,
                        next_to: S_ACCEPT};
    endcase
    return w;
  endfunction

endpackage

/* hdl/hourly_sensor_average_logger.sv */
// a request steps through accept, offset reduction (one pass per depth
//   taken off), branch, and on an hour wrap divider init and steps (if
//   the hour has samples) and hour close, then sample, read and emit, which
//   waits while the last result is not taken; a new request is accepted only
//   after emit, and the averages use an 8-step shared-denominator divider
// reset: slot 0, sums and count cleared, all history entries read as empty (255)
// ----------------------------------------------------------------------------
// hourly_sensor_average_logger
// per-hour temperature and humidity averages kept in a ring, with readback
// ----------------------------------------------------------------------------
module hourly_sensor_average_logger #(
  parameter int HISTORY_DEPTH = hsal_pkg::HISTORY_DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  // request channel
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  hsal_pkg::in_t  in_data_i,
  // result channel
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output hsal_pkg::out_t out_data_o,
  // sample limit register
  input  logic           cfg_we_i,
  input  logic [6:0]     cfg_data_i
);

  localparam int AW    = (HISTORY_DEPTH > 2) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CMP_W = hsal_pkg::CMP_W;
  localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(HISTORY_DEPTH);

  // ---------------------------------------------------------------------------
  // sequencer: step counter and control store
  // ---------------------------------------------------------------------------
  hsal_pkg::step_t  step_q, step_d;
  hsal_pkg::ucode_t uword;
  logic             jump;

  // configuration
  logic [6:0] lim_q, lim_d;

  // latched request
  logic [5:0] minute_q, minute_d;
  logic [6:0] t_q, t_d;
  logic [6:0] h_q, h_d;
  logic [5:0] off_q, off_d;
  logic       smp_ok_q, smp_ok_d;
  logic       first_q, first_d;
  logic       wrap_q, wrap_d;
  logic       up_q, up_d;

  // hour accumulation state
  logic          started_q, started_d;
  logic [5:0]    last_min_q, last_min_d;
  logic [AW-1:0] slot_q, slot_d;
  logic [12:0]   sum_t_q, sum_t_d;
  logic [12:0]   sum_h_q, sum_h_d;
  logic [6:0]    cnt_q, cnt_d;

  // divider lanes, one shared denominator
  logic [7:0] rem_t_q, rem_t_d, quo_t_q, quo_t_d;
  logic [7:0] rem_h_q, rem_h_d, quo_h_q, quo_h_d;
  logic [2:0] iter_q, iter_d;

  // per-request flags
  logic changed_q, changed_d;
  logic taken_q, taken_d;

  // history store
  logic [15:0]              mem_q [HISTORY_DEPTH];
  logic [HISTORY_DEPTH-1:0] ent_vld_q, ent_vld_d;
  logic                     mem_we;
  logic [AW-1:0]            mem_waddr;
  logic [15:0]              mem_wdata;
  logic [AW-1:0]            rd_addr;
  logic [15:0]              rd_data_q;
  logic                     rd_vld_q;

  // result register
  hsal_pkg::out_t out_q, out_d;
  logic           out_valid_q, out_valid_d;

  // helpers
  logic             accept;
  logic             in_smp_ok;
  logic             off_ge;
  logic [CMP_W-1:0] off_ext, slot_ext, slot_inc, pos;
  logic [14:0]      num_t, num_h;
  logic [7:0]       den;
  logic [15:0]      step_t_res, step_h_res;
  logic [7:0]       shown_t, shown_h;

  // one restoring divide step: {remainder, quotient shift register}
  function automatic logic [15:0] div_step(logic [7:0] rem, logic [7:0] quo,
                                           logic [7:0] dv);
    logic [8:0] trial;
    logic [7:0] rem_n;
    logic       qbit;
    trial = {rem, quo[7]};
    qbit  = (trial >= {1'b0, dv});
    rem_n = qbit ? 8'(trial - {1'b0, dv}) : trial[7:0];
    return {rem_n, quo[6:0], qbit};
  endfunction

  assign uword      = hsal_pkg::ucode_rom(step_q);
  assign in_ready_o = (uword.op == hsal_pkg::U_ACCEPT);
  assign accept     = in_valid_i & in_ready_o;

  // sample accepted when the read worked and both values sit in 0..limit
  assign in_smp_ok = in_data_i.sensor_ok
                   & ~in_data_i.temperature_sample[7]
                   & (in_data_i.temperature_sample[6:0] <= lim_q)
                   & ~in_data_i.humidity_sample[7]
                   & (in_data_i.humidity_sample[6:0] <= lim_q);

  assign off_ext  = CMP_W'(off_q);
  assign slot_ext = CMP_W'(slot_q);
  assign off_ge   = (off_ext >= DEPTH_C);
  assign slot_inc = slot_ext + CMP_W'(1);

  // readback slot: current minus offset, wrapped around the ring
  assign pos     = (off_ext > slot_ext) ? (slot_ext + DEPTH_C - off_ext)
                                        : (slot_ext - off_ext);
  assign rd_addr = pos[AW-1:0];

  // rounded average = floor((2*sum + count) / (2*count))
  assign num_t = 15'({sum_t_q, 1'b0}) + 15'(cnt_q);
  assign num_h = 15'({sum_h_q, 1'b0}) + 15'(cnt_q);
  assign den   = {cnt_q, 1'b0};

  assign step_t_res = div_step(rem_t_q, quo_t_q, den);
  assign step_h_res = div_step(rem_h_q, quo_h_q, den);

  // jump condition select
  always_comb begin
    case (uword.cond)
      hsal_pkg::C_NEVER:    jump = 1'b0;
      hsal_pkg::C_NO_REQ:   jump = ~in_valid_i;
      hsal_pkg::C_OFF_GE:   jump = off_ge;
      hsal_pkg::C_NOT_WRAP: jump = ~wrap_q;
      hsal_pkg::C_CNT_ZERO: jump = (cnt_q == 7'd0);
      hsal_pkg::C_DIV_BUSY: jump = (iter_q != 3'd7);
      hsal_pkg::C_OUT_BUSY: jump = out_valid_q & ~out_ready_i;
      default:              jump = 1'b0;
    endcase
  end

  assign step_d = jump ? uword.jump_to : uword.next_to;

  // ---------------------------------------------------------------------------
  // datapath, driven by the current control word
  // ---------------------------------------------------------------------------
  always_comb begin
    lim_d      = cfg_we_i ? cfg_data_i : lim_q;
    minute_d   = minute_q;
    t_d        = t_q;
    h_d        = h_q;
    off_d      = off_q;
    smp_ok_d   = smp_ok_q;
    first_d    = first_q;
    wrap_d     = wrap_q;
    up_d       = up_q;
    started_d  = started_q;
    last_min_d = last_min_q;
    slot_d     = slot_q;
    sum_t_d    = sum_t_q;
    sum_h_d    = sum_h_q;
    cnt_d      = cnt_q;
    rem_t_d    = rem_t_q;
    quo_t_d    = quo_t_q;
    rem_h_d    = rem_h_q;
    quo_h_d    = quo_h_q;
    iter_d     = iter_q;
    changed_d  = changed_q;
    taken_d    = taken_q;
    ent_vld_d  = ent_vld_q;
    mem_we     = 1'b0;
    mem_waddr  = slot_q;
    mem_wdata  = {hsal_pkg::EMPTY_MARK, hsal_pkg::EMPTY_MARK};
    out_d      = out_q;
    // result leaves when taken
    out_valid_d = out_valid_q & ~out_ready_i;

    case (uword.op)
      hsal_pkg::U_ACCEPT: begin
        if (accept) begin
          minute_d = in_data_i.minute_now;
          t_d      = in_data_i.temperature_sample[6:0];
          h_d      = in_data_i.humidity_sample[6:0];
          off_d    = in_data_i.history_offset;
          smp_ok_d = in_smp_ok;
          // first request, hour wrap (minute went back) or a later minute
          first_d  = ~started_q;
          wrap_d   = started_q & (in_data_i.minute_now < last_min_q);
          up_d     = started_q & (in_data_i.minute_now > last_min_q);
        end
      end
      hsal_pkg::U_MOD: begin
        // offset taken modulo the ring depth, one subtract per pass
        if (off_ge) begin
          off_d = 6'(off_ext - DEPTH_C);
        end
      end
      hsal_pkg::U_DIV_INIT: begin
        rem_t_d = {1'b0, num_t[14:8]};
        quo_t_d = num_t[7:0];
        rem_h_d = {1'b0, num_h[14:8]};
        quo_h_d = num_h[7:0];
        iter_d  = 3'd0;
      end
      hsal_pkg::U_DIV_STEP: begin
        rem_t_d = step_t_res[15:8];
        quo_t_d = step_t_res[7:0];
        rem_h_d = step_h_res[15:8];
        quo_h_d = step_h_res[7:0];
        iter_d  = iter_q + 3'd1;
      end
      hsal_pkg::U_CLOSE_HOUR: begin
        // hour average, or empty marker for an hour without samples
        mem_we    = 1'b1;
        mem_waddr = slot_q;
        if (cnt_q != 7'd0) begin
          mem_wdata = {quo_t_q, quo_h_q};
        end
        ent_vld_d[slot_q] = 1'b1;
        slot_d  = (slot_inc >= DEPTH_C) ? '0 : slot_inc[AW-1:0];
        sum_t_d = '0;
        sum_h_d = '0;
        cnt_d   = '0;
      end
      hsal_pkg::U_SAMPLE: begin
        changed_d = first_q | wrap_q | up_q;
        taken_d   = 1'b0;
        if ((first_q | wrap_q | up_q) & smp_ok_q) begin
          // live sample into the open slot
          mem_we            = 1'b1;
          mem_wdata         = {1'b0, t_q, 1'b0, h_q};
          ent_vld_d[slot_q] = 1'b1;
          sum_t_d           = sum_t_q + 13'(t_q);
          sum_h_d           = sum_h_q + 13'(h_q);
          cnt_d             = cnt_q + 7'd1;
          taken_d           = 1'b1;
        end else if (wrap_q) begin
          // new hour opened without a sample
          mem_we            = 1'b1;
          ent_vld_d[slot_q] = 1'b1;
        end
        if (first_q | wrap_q | up_q) begin
          last_min_d = minute_q;
        end
        started_d = 1'b1;
      end
      hsal_pkg::U_EMIT: begin
        if (~out_valid_q | out_ready_i) begin
          out_d.temperature_shown = shown_t;
          out_d.humidity_shown    = shown_h;
          out_d.entry_empty       = (shown_t == hsal_pkg::EMPTY_MARK);
          out_d.data_changed      = changed_q;
          out_d.sample_taken      = taken_q;
          out_d.current_slot      = slot_ext[5:0];
          out_valid_d             = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // never-written entries read back as the empty marker
  assign shown_t = rd_vld_q ? rd_data_q[15:8] : hsal_pkg::EMPTY_MARK;
  assign shown_h = rd_vld_q ? rd_data_q[7:0]  : hsal_pkg::EMPTY_MARK;

  // ---------------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= hsal_pkg::S_ACCEPT;
      lim_q       <= hsal_pkg::LIMIT_RESET;
      started_q   <= 1'b0;
      last_min_q  <= '0;
      slot_q      <= '0;
      sum_t_q     <= '0;
      sum_h_q     <= '0;
      cnt_q       <= '0;
      ent_vld_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      lim_q       <= lim_d;
      started_q   <= started_d;
      last_min_q  <= last_min_d;
      slot_q      <= slot_d;
      sum_t_q     <= sum_t_d;
      sum_h_q     <= sum_h_d;
      cnt_q       <= cnt_d;
      ent_vld_q   <= ent_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    minute_q  <= minute_d;
    t_q       <= t_d;
    h_q       <= h_d;
    off_q     <= off_d;
    smp_ok_q  <= smp_ok_d;
    first_q   <= first_d;
    wrap_q    <= wrap_d;
    up_q      <= up_d;
    rem_t_q   <= rem_t_d;
    quo_t_q   <= quo_t_d;
    rem_h_q   <= rem_h_d;
    quo_h_q   <= quo_h_d;
    iter_q    <= iter_d;
    changed_q <= changed_d;
    taken_q   <= taken_d;
    out_q     <= out_d;
  end

  // history memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (uword.op == hsal_pkg::U_READ) begin
      rd_data_q <= mem_q[rd_addr];
      rd_vld_q  <= ent_vld_q[rd_addr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the hourly sensor average logger: requests with
// random gaps, results with random backpressure, a request-level model of the
// hourly ring checked field by field against every result
// ----------------------------------------------------------------------------
module tb;

  localparam int DEPTH     = hsal_pkg::HISTORY_DEPTH_DEF;
  localparam int MAX_CYCLE = 500000;

  // clock, reset and block ports, all known from time zero
  logic           clk_i;
  logic           rst_ni     = 1'b0;
  logic           in_valid   = 1'b0;
  logic           in_ready;
  hsal_pkg::in_t  in_data    = '0;
  logic           out_valid;
  logic           out_ready  = 1'b0;
  hsal_pkg::out_t out_data;
  logic           cfg_we     = 1'b0;
  logic [6:0]     cfg_data   = '0;

  // bench bookkeeping
  int             err_count  = 0;
  int             cycle_cnt  = 0;
  int             stall_left = 0;
  bit             no_idle    = 1'b0;
  hsal_pkg::out_t expected_q[$];

  // model of the logger: hourly ring, running sums and the limit register
  logic [7:0] temp_log[DEPTH];
  logic [7:0] hum_log[DEPTH];
  int         slot;
  int         t_sum;
  int         h_sum;
  int         n_samples;
  int         last_min;
  bit         started;
  int         limit;

  hourly_sensor_average_logger u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // model
  // ---------------------------------------------------------------------------

  // round half up: floor((2*sum + n) / (2*n))
  function automatic logic [7:0] hour_mean(int sum, int n);
    return 8'((2 * sum + n) / (2 * n));
  endfunction

  // live write of a valid sample into the open slot, plus the running sums
  function automatic bit store_sample(bit ok_sample, int t, int h);
    if (!ok_sample) return 1'b0;
    temp_log[slot] = 8'(t);
    hum_log[slot]  = 8'(h);
    t_sum     += t;
    h_sum     += h;
    n_samples += 1;
    return 1'b1;
  endfunction

  // advance the model by one request and return the result it must produce
  function automatic hsal_pkg::out_t log_update(hsal_pkg::in_t req);
    hsal_pkg::out_t exp_r;
    int   t;
    int   h;
    int   off;
    int   pos;
    bit   ok_sample;
    bit   changed;
    bit   taken;
    t = $signed(req.temperature_sample);
    h = $signed(req.humidity_sample);
    ok_sample = req.sensor_ok && t >= 0 && t <= limit && h >= 0 && h <= limit;
    changed = 1'b1;
    taken   = 1'b0;
    if (!started) begin
      // first request ever opens the log
      started  = 1'b1;
      taken    = store_sample(ok_sample, t, h);
      last_min = req.minute_now;
    end else if (req.minute_now < last_min) begin
      // minute wrapped: close the hour with its mean, or mark it empty
      if (n_samples != 0) begin
        temp_log[slot] = hour_mean(t_sum, n_samples);
        hum_log[slot]  = hour_mean(h_sum, n_samples);
      end else begin
        temp_log[slot] = hsal_pkg::EMPTY_MARK;
        hum_log[slot]  = hsal_pkg::EMPTY_MARK;
      end
      slot      = (slot + 1 >= DEPTH) ? 0 : slot + 1;
      t_sum     = 0;
      h_sum     = 0;
      n_samples = 0;
      last_min  = req.minute_now;
      // the wrapping request opens the new hour, empty if its sample is bad
      if (ok_sample) begin
        taken = store_sample(1'b1, t, h);
      end else begin
        temp_log[slot] = hsal_pkg::EMPTY_MARK;
        hum_log[slot]  = hsal_pkg::EMPTY_MARK;
      end
    end else if (req.minute_now > last_min) begin
      taken    = store_sample(ok_sample, t, h);
      last_min = req.minute_now;
    end else begin
      // same minute again leaves everything alone
      changed = 1'b0;
    end
    // readback after the update, offset folded into the ring
    off = req.history_offset % DEPTH;
    pos = (off > slot) ? DEPTH - (off - slot) : slot - off;
    exp_r.temperature_shown = temp_log[pos];
    exp_r.humidity_shown    = hum_log[pos];
    exp_r.entry_empty       = (temp_log[pos] == hsal_pkg::EMPTY_MARK);
    exp_r.data_changed      = changed;
    exp_r.sample_taken      = taken;
    exp_r.current_slot      = 6'(slot);
    return exp_r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic hsal_pkg::in_t make_req(int minute, int t, int h, bit ok, int off);
    hsal_pkg::in_t r;
    r.minute_now         = 6'(minute);
    r.temperature_sample = 8'(t);
    r.humidity_sample    = 8'(h);
    r.sensor_ok          = ok;
    r.history_offset     = 6'(off);
    return r;
  endfunction

  // idle length: mostly none or short, now and then a long one
  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_error(string msg);
    if (err_count < 200) $display("[%0t] error: %s", $time, msg);
    err_count++;
  endtask

  // present one request, hold it until accepted, log its expected result;
  // valid stays high into the next request when there is no gap
  task automatic send_request(hsal_pkg::in_t req);
    int gap;
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk_i); while (!in_ready);
    expected_q.push_back(log_update(req));
    gap = no_idle ? 0 : rand_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // drop valid and let every outstanding result come back
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  // limit register is only written with the logger idle
  task automatic set_sample_limit(int v);
    wait_quiet();
    cfg_we   <= 1'b1;
    cfg_data <= 7'(v);
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    limit = v;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // hand-picked requests at the reset limit of 99
  task automatic test_directed();
    send_request(make_req(0, 25, 60, 1, 0));     // first request stores
    send_request(make_req(0, 30, 30, 1, 0));     // same minute, no change
    send_request(make_req(1, 10, 10, 0, 1));     // failed sensor read
    send_request(make_req(2, -1, 50, 1, 2));     // negative temperature
    send_request(make_req(3, 50, 100, 1, 3));    // humidity just over limit
    send_request(make_req(4, 99, 99, 1, 59));    // both right at the limit
    send_request(make_req(5, 0, 0, 1, 60));      // zero sample, offset folds to 0
    send_request(make_req(6, -128, 127, 1, 63)); // field extremes, rejected
    send_request(make_req(7, 127, -128, 0, 0));
    send_request(make_req(0, 1, 2, 1, 0));       // wrap closes hour with mean
    send_request(make_req(1, 2, 3, 1, 1));       // half values round up later
    send_request(make_req(0, 5, 5, 0, 1));       // wrap with bad sample: empty slot
    send_request(make_req(30, 50, 50, 0, 2));
    send_request(make_req(10, 5, 5, 0, 3));      // wrap with no samples in hour
    send_request(make_req(63, 40, 40, 1, 0));    // minute beyond 59
    send_request(make_req(62, 41, 41, 1, 1));    // wrap from 63
    send_request(make_req(0, 127, 127, 1, 0));
    wait_quiet();
  endtask

  // limit register at both ends and in between
  task automatic test_limit_register();
    int l;
    set_sample_limit(0);
    send_request(make_req(1, 0, 0, 1, 0));
    send_request(make_req(2, 1, 0, 1, 0));
    send_request(make_req(3, 0, 1, 1, 1));
    send_request(make_req(4, 0, 0, 0, 0));
    set_sample_limit(127);
    send_request(make_req(5, 127, 127, 1, 0));
    send_request(make_req(6, -128, 0, 1, 0));
    send_request(make_req(7, 0, -1, 1, 0));
    send_request(make_req(0, 64, 64, 1, 1));     // mean of 0 and 127
    l = $urandom_range(1, 126);
    set_sample_limit(l);
    send_request(make_req(10, l, l, 1, 0));
    send_request(make_req(11, l + 1, 0, 1, 0));
    send_request(make_req(12, 0, l + 1, 1, 1));
    set_sample_limit(hsal_pkg::LIMIT_RESET);
  endtask

  // two requests per hour for more than a full lap of the ring
  task automatic test_slot_rollover();
    for (int hr = 0; hr < DEPTH + 4; hr++) begin
      send_request(make_req(20, hr, 99 - hr, 1, $urandom_range(0, 63)));
      send_request(make_req(5, hr + 1, hr, (hr % 4) != 0, $urandom_range(0, 2)));
    end
    wait_quiet();
  endtask

  // mostly well-formed minute progressions with random samples, plus noise
  task automatic test_random_traffic();
    int   lm;
    int   r;
    int   minute;
    int   t;
    int   h;
    int   step_max;
    int   lim;
    bit   ok;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0:       lim = hsal_pkg::LIMIT_RESET;
        2:       lim = 127;
        3:       lim = 0;
        default: lim = $urandom_range(1, 126);
      endcase
      set_sample_limit(lim);
      for (int i = 0; i < 130; i++) begin
        if (i % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
        lm = last_min;
        r  = $urandom_range(0, 99);
        if (r < 10) begin
          minute = $urandom_range(0, 63);
        end else if (r < 22) begin
          minute = lm;
        end else if ((r < 34 && lm > 0) || lm >= 59) begin
          minute = $urandom_range(0, (lm > 6) ? 6 : lm - 1);
        end else begin
          step_max = (59 - lm < 6) ? 59 - lm : 6;
          minute   = lm + $urandom_range(1, step_max);
        end
        r = $urandom_range(0, 9);
        if (r < 6) begin
          t  = $urandom_range(0, lim);
          h  = $urandom_range(0, lim);
          ok = 1'b1;
        end else if (r < 7) begin
          // boundary around the limit
          t  = lim + $urandom_range(0, 1);
          h  = lim + $urandom_range(0, 1);
          ok = 1'b1;
        end else begin
          t  = $urandom_range(0, 255);
          h  = $urandom_range(0, 255);
          ok = $urandom_range(0, 1);
        end
        send_request(make_req(minute, t, h, ok,
                              ($urandom_range(0, 2) == 0) ? $urandom_range(0, 3)
                                                          : $urandom_range(0, 63)));
      end
      no_idle = 1'b0;
    end
    wait_quiet();
  endtask

  // ---------------------------------------------------------------------------
  // result side: random backpressure and the field-by-field check
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (no_idle) begin
      out_ready  <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (out_ready) begin
      out_ready  <= 1'b0;
      stall_left <= rand_gap();
    end else begin
      out_ready  <= 1'b1;
      stall_left <= $urandom_range(0, 12);
    end
  end

  always @(posedge clk_i) begin : check_results
    hsal_pkg::out_t exp_r;
    if (rst_ni && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        report_error("result with no request outstanding");
      end else begin
        exp_r = expected_q.pop_front();
        if (out_data.temperature_shown !== exp_r.temperature_shown)
          report_error($sformatf("temperature_shown %0d, want %0d",
                                 out_data.temperature_shown, exp_r.temperature_shown));
        if (out_data.humidity_shown !== exp_r.humidity_shown)
          report_error($sformatf("humidity_shown %0d, want %0d",
                                 out_data.humidity_shown, exp_r.humidity_shown));
        if (out_data.entry_empty !== exp_r.entry_empty)
          report_error($sformatf("entry_empty %b, want %b",
                                 out_data.entry_empty, exp_r.entry_empty));
        if (out_data.data_changed !== exp_r.data_changed)
          report_error($sformatf("data_changed %b, want %b",
                                 out_data.data_changed, exp_r.data_changed));
        if (out_data.sample_taken !== exp_r.sample_taken)
          report_error($sformatf("sample_taken %b, want %b",
                                 out_data.sample_taken, exp_r.sample_taken));
        if (out_data.current_slot !== exp_r.current_slot)
          report_error($sformatf("current_slot %0d, want %0d",
                                 out_data.current_slot, exp_r.current_slot));
      end
    end
  end

  // hang guard
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > MAX_CYCLE) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_cnt, expected_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    // model starts from the reset state: empty ring, limit at 99
    foreach (temp_log[i]) begin
      temp_log[i] = hsal_pkg::EMPTY_MARK;
      hum_log[i]  = hsal_pkg::EMPTY_MARK;
    end
    slot      = 0;
    t_sum     = 0;
    h_sum     = 0;
    n_samples = 0;
    last_min  = 0;
    started   = 1'b0;
    limit     = hsal_pkg::LIMIT_RESET;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_limit_register();
    test_slot_rollover();
    test_random_traffic();

    // let any stray result show up before the verdict
    wait_quiet();
    repeat (40) @(posedge clk_i);
    if (err_count == 0 && expected_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
